>>> hdl/mdp_pkg.sv
package mdp_pkg;

    localparam logic [5:0] LAYOUT_LEN = 6'd53;

    localparam logic [5:0] POS_VENDOR_DONE    = 6'd13;
    localparam logic [5:0] POS_DEVICE_DONE    = 6'd22;
    localparam logic [5:0] POS_SUBVENDOR_DONE = 6'd32;
    localparam logic [5:0] POS_SUBDEVICE_DONE = 6'd42;
    localparam logic [5:0] POS_BASE_DONE      = 6'd46;
    localparam logic [5:0] POS_SUB_DONE       = 6'd50;
    localparam logic [5:0] POS_PROG_DONE      = 6'd53;

    localparam logic [7:0] CHAR_HEX   = 8'h23;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    typedef struct packed {
        logic [31:0] vendor_id;
        logic [31:0] device_id;
        logic [31:0] subsys_vendor_id;
        logic [31:0] subsys_device_id;
        logic [7:0]  base_class_code;
        logic [7:0]  sub_class_code;
        logic [7:0]  prog_interface;
        logic        parse_status;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex_digit;

    // Expected character at each layout position; CHAR_HEX marks a hex digit.
    function automatic logic [7:0] layout_char(input logic [5:0] pos);
        logic [7:0] ch;
        unique case (pos)
            6'd0:  ch = 8'h70;
            6'd1:  ch = 8'h63;
            6'd2:  ch = 8'h69;
            6'd3:  ch = 8'h3A;
            6'd4:  ch = 8'h76;
            6'd13: ch = 8'h64;
            6'd22: ch = 8'h73;
            6'd23: ch = 8'h76;
            6'd32: ch = 8'h73;
            6'd33: ch = 8'h64;
            6'd42: ch = 8'h62;
            6'd43: ch = 8'h63;
            6'd46: ch = 8'h73;
            6'd47: ch = 8'h63;
            6'd50: ch = 8'h69;
            default: ch = CHAR_HEX;
        endcase
        return ch;
    endfunction

    function automatic t_hex_digit hex_digit(input logic [7:0] c);
        t_hex_digit d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.value = 4'(c - 8'h37);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

>>> hdl/mdp_step.sv
module mdp_step
    import mdp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output t_result    o_result
);

    logic [5:0]  r_pos,       n_pos;
    logic [31:0] r_acc,       n_acc;
    logic [31:0] r_vendor,    n_vendor;
    logic [31:0] r_device,    n_device;
    logic [31:0] r_subvendor, n_subvendor;
    logic [31:0] r_subdevice, n_subdevice;
    logic [23:0] r_class,     n_class;
    logic        r_err,       n_err;
    logic        r_ended,     n_ended;
    logic [7:0]  w_expect;
    t_hex_digit  w_digit;

    assign w_expect = layout_char(r_pos);
    assign w_digit  = hex_digit(i_char);

    always_comb begin
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_vendor    = r_vendor;
        n_device    = r_device;
        n_subvendor = r_subvendor;
        n_subdevice = r_subdevice;
        n_class     = r_class;
        n_err       = r_err;
        n_ended     = r_ended;
        if (!r_ended && !r_err) begin
            if (i_char == CHAR_NUL) begin
                n_ended = 1'b1;
                if (r_pos < LAYOUT_LEN) begin
                    n_err = 1'b1;
                end
            end else if (r_pos >= LAYOUT_LEN) begin
                if (i_char != CHAR_SPACE && i_char != CHAR_TAB && i_char != CHAR_LF) begin
                    n_err = 1'b1;
                end
            end else if (w_expect == CHAR_HEX) begin
                if (!w_digit.ok) begin
                    n_err = 1'b1;
                end else begin
                    n_acc = {r_acc[27:0], w_digit.value};
                    n_pos = r_pos + 6'd1;
                    unique case (n_pos)
                        POS_VENDOR_DONE:    n_vendor    = n_acc;
                        POS_DEVICE_DONE:    n_device    = n_acc;
                        POS_SUBVENDOR_DONE: n_subvendor = n_acc;
                        POS_SUBDEVICE_DONE: n_subdevice = n_acc;
                        POS_BASE_DONE:      n_class[23:16] = n_acc[7:0];
                        POS_SUB_DONE:       n_class[15:8]  = n_acc[7:0];
                        POS_PROG_DONE:      n_class[7:0]   = n_acc[7:0];
                        default: ;
                    endcase
                end
            end else if (i_char == w_expect) begin
                n_acc = 32'd0;
                n_pos = r_pos + 6'd1;
            end else begin
                n_err = 1'b1;
            end
        end
    end

    always_comb begin
        o_result.vendor_id        = n_vendor;
        o_result.device_id        = n_device;
        o_result.subsys_vendor_id = n_subvendor;
        o_result.subsys_device_id = n_subdevice;
        o_result.base_class_code  = n_class[23:16];
        o_result.sub_class_code   = n_class[15:8];
        o_result.prog_interface   = n_class[7:0];
        o_result.parse_status     = n_err || (n_pos < LAYOUT_LEN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_pos       <= 6'd0;
            r_acc       <= 32'd0;
            r_vendor    <= 32'd0;
            r_device    <= 32'd0;
            r_subvendor <= 32'd0;
            r_subdevice <= 32'd0;
            r_class     <= 24'd0;
            r_err       <= 1'b0;
            r_ended     <= 1'b0;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_acc       <= n_acc;
            r_vendor    <= n_vendor;
            r_device    <= n_device;
            r_subvendor <= n_subvendor;
            r_subdevice <= n_subdevice;
            r_class     <= n_class;
            r_err       <= n_err;
            r_ended     <= n_ended;
        end
    end

endmodule

>>> hdl/mdp_out.sv
module mdp_out
    import mdp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> hdl/pci_modalias_parser.sv
// Output: the result register loads the result as the string's last byte is stepped.
// Throughput: one byte per cycle; the byte register advances whenever the result register
// can take a result or the byte does not end a string.
// Reset: synchronous, active low; it clears the parse state and empties both registers.
// After each result the parse state returns to its reset values for the next string.
module pci_modalias_parser
    import mdp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // char_byte[7:0]
    input  logic         s_axis_tlast,   // last_char
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vendor_id[31:0], device_id[63:32], subsys_vendor_id[95:64],
    // subsys_device_id[127:96], base_class_code[135:128], sub_class_code[143:136],
    // prog_interface[151:144]
    output logic [151:0] m_axis_tdata,
    output logic         m_axis_tuser    // parse_status
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       w_step;
    logic       w_load;
    t_result    w_step_result;
    t_result    w_out_result;

    assign w_step        = r_in_valid && (!r_in_last || !m_axis_tvalid || m_axis_tready);
    assign w_load        = w_step && r_in_last;
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    mdp_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_char   (r_in_char),
        .i_last   (r_in_last),
        .o_result (w_step_result)
    );

    mdp_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_step_result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (w_out_result)
    );

    assign m_axis_tdata = {w_out_result.prog_interface, w_out_result.sub_class_code,
                           w_out_result.base_class_code, w_out_result.subsys_device_id,
                           w_out_result.subsys_vendor_id, w_out_result.device_id,
                           w_out_result.vendor_id};
    assign m_axis_tuser = w_out_result.parse_status;

    a_load_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> m_axis_tvalid)
        else $error("result register did not take a finished string");

    a_stalled_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while a string end waits on a full result register");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_in_valid)
        else $error("accepted byte was lost");

endmodule
